[rtl/core/chained_hash_map_top_assert.svh]
// assertion macros for the chained hash map top level
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef CHAINED_HASH_MAP_TOP_ASSERT_SVH
`define CHAINED_HASH_MAP_TOP_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define CHM_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("chained hash map assertion failed");

// antecedent implies consequent in the next cycle
`define CHM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("chained hash map assertion failed");

`endif

[rtl/core/chm_pkg.sv]
// shared types and constants of the chained hash map
// no dependencies
`timescale 1ns / 1ps

package chm_pkg;

  localparam int unsigned KeyBits    = 32;
  localparam int unsigned HandleBits = 32;
  localparam int unsigned CountBits  = 10;

  localparam logic [1:0] KindPut    = 2'd0;
  localparam logic [1:0] KindLookup = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;
  localparam logic [1:0] KindNone   = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic                  found;
    logic [HandleBits-1:0] handle_out;
    logic                  table_full;
    logic [CountBits-1:0]  entry_count;
  } out_item_t;

endpackage

[rtl/core/chm_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/chained_hash_map_top.sv]
// chained hash map: key to handle map with separate chaining over a slot pool
// depends on chm_pkg, chm_ram and chained_hash_map_top_assert.svh
//
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one operation
//   (put, lookup or remove) with key and handle; output channel
//   out_valid_o / out_stall_i / out_data_o returns one result per operation.
//   one operation is handled at a time; in_stall_o is high while it runs.
//   steps: the bucket index is taken from the low key bits for a power of
//   two bucket count, else by a reciprocal multiply, then a subtract; then
//   the head read, a read and a compare per chain link visited on the slot
//   ram read port plus a check that sees the chain end on a miss, a decide
//   step, a link step for a new entry on an insert, a pop step before it
//   when that insert takes a slot off the freed stack, and a load of the
//   output register. after reset the bucket heads are cleared one per
//   cycle, with in_stall_o high. a finished result waits in the output
//   register while out_stall_i is high; the next transaction is taken
//   meanwhile but its result waits until the register frees up.
`timescale 1ns / 1ps
`include "chained_hash_map_top_assert.svh"

module chained_hash_map_top
  import chm_pkg::*;
#(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned ENTRIES = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned PW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = KeyBits + HandleBits + PW;
  localparam int unsigned CW = PW;
  localparam int unsigned PrW = 2 * KeyBits + 1;
  localparam bit BucketsPow2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [PW-1:0] NilSlot = PW'(ENTRIES);
  localparam logic [BW-1:0] LastBucket = BW'(BUCKETS - 1);
  localparam logic [BW-1:0] BucketsLo = BW'(BUCKETS);
  // ceil(2^(KeyBits+BW) / BUCKETS), exact quotient for every key
  localparam logic [KeyBits:0] RecipM =
    (KeyBits + 1)'(((PrW'(1) << (KeyBits + BW)) + PrW'(BUCKETS) - PrW'(1)) / PrW'(BUCKETS));

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_HEADW = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_ACT   = 4'd7;
  localparam logic [3:0] S_POP   = 4'd8;
  localparam logic [3:0] S_INS   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_MOD   = 4'd11;

  logic [3:0] state_q, state_d;
  logic [1:0] kind_q, kind_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [HandleBits-1:0] handle_q, handle_d, hout_q, hout_d;
  logic [PrW-1:0] prod_q, prod_d;
  logic [BW-1:0] bucket_q, bucket_d, clr_q, clr_d;
  logic [PW-1:0] head_q, head_d, cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic [SW-1:0] ent_q, ent_d, prev_ent_q, prev_ent_d;
  logic found_q, found_d, full_q, full_d, pop_q, pop_d;
  logic [PW-1:0] top_q, top_d, fresh_q, fresh_d;
  logic [CW-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic          head_we;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [PW-1:0] head_wdata, head_rdata;
  logic          slot_we;
  logic [IW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr;
  logic [IW-1:0] stk_wdata, stk_rdata;
  logic [IW-1:0] ins_slot;

  chm_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  chm_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  chm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign ins_slot = pop_q ? stk_rdata : fresh_q[IW-1:0];

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    handle_d    = handle_q;
    hout_d      = hout_q;
    prod_d      = prod_q;
    bucket_d    = bucket_q;
    clr_d       = clr_q;
    head_d      = head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    steps_d     = steps_q;
    ent_d       = ent_q;
    prev_ent_d  = prev_ent_q;
    found_d     = found_q;
    full_d      = full_q;
    pop_d       = pop_q;
    top_d       = top_q;
    fresh_d     = fresh_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    head_we    = 1'b0;
    head_waddr = bucket_q;
    head_wdata = NilSlot;
    head_raddr = bucket_q;
    slot_we    = 1'b0;
    slot_waddr = cur_q[IW-1:0];
    slot_wdata = '0;
    slot_raddr = cur_q[IW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = top_q[IW-1:0];
    stk_wdata  = cur_q[IW-1:0];
    stk_raddr  = IW'(top_q - PW'(1));

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = NilSlot;
        clr_d      = clr_q + BW'(1);
        if (clr_q == LastBucket) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d   = in_data_i.kind;
          key_d    = in_data_i.key;
          handle_d = in_data_i.handle_in;
          found_d  = 1'b0;
          hout_d   = '0;
          full_d   = 1'b0;
          state_d  = (in_data_i.kind == KindNone) ? S_OUT : S_HASH;
        end
      end
      S_HASH: begin
        if (BucketsPow2) begin
          bucket_d = key_q[BW-1:0];
          state_d  = S_HEAD;
        end else begin
          // quotient by reciprocal multiplication
          prod_d  = PrW'(key_q) * PrW'(RecipM);
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // remainder is below BUCKETS, so the low bits are enough
        bucket_d = key_q[BW-1:0] - BW'(prod_q[KeyBits+BW +: BW] * BucketsLo);
        state_d  = S_HEAD;
      end
      S_HEAD: begin
        head_raddr = bucket_q;
        state_d    = S_HEADW;
      end
      S_HEADW: begin
        head_d  = head_rdata;
        cur_d   = head_rdata;
        prev_d  = NilSlot;
        steps_d = '0;
        state_d = S_RD;
      end
      S_RD: begin
        if (cur_q >= NilSlot || steps_q == NilSlot) begin
          state_d = S_ACT;
        end else begin
          slot_raddr = cur_q[IW-1:0];
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        if (slot_rdata[SW-1 -: KeyBits] == key_q) begin
          found_d = 1'b1;
          ent_d   = slot_rdata;
          state_d = S_ACT;
        end else begin
          prev_d     = cur_q;
          prev_ent_d = slot_rdata;
          cur_d      = slot_rdata[PW-1:0];
          steps_d    = steps_q + PW'(1);
          state_d    = S_RD;
        end
      end
      S_ACT: begin
        state_d = S_OUT;
        case (kind_q)
          KindPut: begin
            if (found_q) begin
              slot_we    = 1'b1;
              slot_waddr = cur_q[IW-1:0];
              slot_wdata = {key_q, handle_q, ent_q[PW-1:0]};
            end else if (top_q > '0) begin
              pop_d   = 1'b1;
              state_d = S_POP;
            end else if (fresh_q < NilSlot) begin
              pop_d   = 1'b0;
              state_d = S_INS;
            end else begin
              full_d = 1'b1;
            end
          end
          KindLookup: begin
            if (found_q) begin
              hout_d = ent_q[PW +: HandleBits];
            end
          end
          KindRemove: begin
            if (found_q) begin
              hout_d = ent_q[PW +: HandleBits];
              if (prev_q != NilSlot) begin
                slot_we    = 1'b1;
                slot_waddr = prev_q[IW-1:0];
                slot_wdata = {prev_ent_q[SW-1:PW], ent_q[PW-1:0]};
              end else begin
                head_we    = 1'b1;
                head_waddr = bucket_q;
                head_wdata = ent_q[PW-1:0];
              end
              if (top_q < NilSlot) begin
                stk_we    = 1'b1;
                stk_waddr = top_q[IW-1:0];
                stk_wdata = cur_q[IW-1:0];
                top_d     = top_q + PW'(1);
              end
              if (count_q > '0) begin
                count_d = count_q - CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        stk_raddr = IW'(top_q - PW'(1));
        state_d   = S_INS;
      end
      S_INS: begin
        slot_we    = 1'b1;
        slot_waddr = ins_slot;
        slot_wdata = {key_q, handle_q, head_q};
        head_we    = 1'b1;
        head_waddr = bucket_q;
        head_wdata = PW'(ins_slot);
        // count rises with either a stack pop or a fresh slot
        if (pop_q) begin
          top_d = top_q - PW'(1);
        end else begin
          fresh_d = fresh_q + PW'(1);
        end
        count_d = count_q + CW'(1);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.found       = found_q && (kind_q != KindNone);
          out_d.handle_out  = hout_q;
          out_d.table_full  = full_q;
          out_d.entry_count = CountBits'(count_q);
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      top_q       <= '0;
      fresh_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      top_q       <= top_d;
      fresh_q     <= fresh_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_q      <= key_d;
    handle_q   <= handle_d;
    hout_q     <= hout_d;
    prod_q     <= prod_d;
    bucket_q   <= bucket_d;
    head_q     <= head_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    steps_q    <= steps_d;
    ent_q      <= ent_d;
    prev_ent_q <= prev_ent_d;
    found_q    <= found_d;
    full_q     <= full_d;
    pop_q      <= pop_d;
    out_q      <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // every allocated slot is either stored or sitting on the freed stack
  `CHM_ASSERT(a_pool_balance, count_q == CW'(fresh_q - top_q))
  // only one transaction in flight
  `CHM_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)
  // a refused put never reports a hit or a handle
  `CHM_ASSERT(a_full_clean,
    !(out_valid_o && out_data_o.table_full) || (!out_data_o.found && out_data_o.handle_out == '0))

endmodule

[tb/chained_hash_map_top_tb.sv]
// self-checking testbench for chained_hash_map_top: random and directed map operations
// depends on chm_pkg and chained_hash_map_top; holds its own map model for prediction
`timescale 1ns / 1ps

module chained_hash_map_top_tb;
  import chm_pkg::*;

  localparam int unsigned NumBuckets = 256;
  localparam int unsigned NumSlots   = 512;
  localparam int unsigned NilSlot    = NumSlots;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  chained_hash_map_top #(
    .BUCKETS(NumBuckets),
    .ENTRIES(NumSlots)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // map model state
  int unsigned           head_of[NumBuckets];
  logic [KeyBits-1:0]    key_of[NumSlots];
  logic [HandleBits-1:0] handle_of[NumSlots];
  int unsigned           next_of[NumSlots];
  int unsigned           freed_stack[NumSlots];
  int unsigned           freed_depth;
  int unsigned           fresh_next;
  int unsigned           live_count;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  logic [KeyBits-1:0] used_keys[$];

  int unsigned mismatches;
  int unsigned ops_sent;
  int unsigned results_seen;
  int unsigned hits_seen;
  int unsigned full_seen;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          long_hold_req;

  function automatic out_item_t apply_op(in_item_t op);
    out_item_t   res;
    int unsigned bkt;
    int unsigned cur;
    int unsigned prv;
    int unsigned hit;
    int unsigned steps;
    int unsigned slot;
    res = '0;
    bkt = op.key % NumBuckets;
    hit = NilSlot;
    prv = NilSlot;
    if (op.kind != KindNone) begin
      cur = head_of[bkt];
      steps = 0;
      while (cur < NilSlot && steps < NumSlots && hit == NilSlot) begin
        if (key_of[cur] == op.key) hit = cur;
        else begin
          prv = cur;
          cur = next_of[cur];
        end
        steps++;
      end
      res.found = (hit != NilSlot);
    end
    case (op.kind)
      KindPut: begin
        if (hit != NilSlot) handle_of[hit] = op.handle_in;
        else begin
          slot = NilSlot;
          if (freed_depth > 0) begin
            freed_depth--;
            slot = freed_stack[freed_depth];
          end else if (fresh_next < NumSlots) begin
            slot = fresh_next;
            fresh_next++;
          end
          if (slot != NilSlot) begin
            key_of[slot] = op.key;
            handle_of[slot] = op.handle_in;
            next_of[slot] = head_of[bkt];
            head_of[bkt] = slot;
            live_count++;
          end else res.table_full = 1'b1;
        end
      end
      KindLookup: if (hit != NilSlot) res.handle_out = handle_of[hit];
      KindRemove: begin
        if (hit != NilSlot) begin
          res.handle_out = handle_of[hit];
          if (prv != NilSlot) next_of[prv] = next_of[hit];
          else head_of[bkt] = next_of[hit];
          if (freed_depth < NumSlots) begin
            freed_stack[freed_depth] = hit;
            freed_depth++;
          end
          if (live_count > 0) live_count--;
        end
      end
      default: ;
    endcase
    res.entry_count = live_count[CountBits-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 3) return $urandom_range(20, 60);
    if ($urandom_range(0, 99) < 40) return 0;
    return $urandom_range(1, 3);
  endfunction

  // keys mostly come from a small reused set so chains grow and hits occur
  function automatic logic [KeyBits-1:0] pick_key();
    logic [KeyBits-1:0] k;
    if (used_keys.size() > 0 && $urandom_range(0, 99) < 65)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    case ($urandom_range(0, 3))
      0: k = $urandom_range(0, 7) * NumBuckets + $urandom_range(0, 3);
      default: k = $urandom();
    endcase
    used_keys.push_back(k);
    if (used_keys.size() > 700) void'(used_keys.pop_front());
    return k;
  endfunction

  function automatic in_item_t make_op(logic [1:0] kind, logic [KeyBits-1:0] key,
                                       logic [HandleBits-1:0] h);
    in_item_t op;
    op.kind = kind;
    op.key = key;
    op.handle_in = h;
    return op;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: predicts at acceptance so order matches the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_op(in_data_i));
        ops_sent++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transaction
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ops.size() > 0) begin
        in_data_i <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data_o), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.found != want.found)
            report_mismatch("found", 64'(out_data_o.found), 64'(want.found));
          if (out_data_o.handle_out != want.handle_out)
            report_mismatch("handle_out", 64'(out_data_o.handle_out), 64'(want.handle_out));
          if (out_data_o.table_full != want.table_full)
            report_mismatch("table_full", 64'(out_data_o.table_full), 64'(want.table_full));
          if (out_data_o.entry_count != want.entry_count)
            report_mismatch("entry_count", 64'(out_data_o.entry_count),
                            64'(want.entry_count));
          if (want.found) hits_seen++;
          if (want.table_full) full_seen++;
        end
      end
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        hold_left <= 400;
        out_stall_i <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= (hold_left > 1);
      end else if ($urandom_range(0, 99) < 25) begin
        hold_left <= pick_gap();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [KeyBits-1:0] k;
    rst_ni = 1'b0;
    mismatches = 0;
    ops_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    full_seen = 0;
    long_hold_req = 1'b0;
    for (int i = 0; i < NumBuckets; i++) head_of[i] = NilSlot;
    for (int i = 0; i < NumSlots; i++) begin
      key_of[i] = '0;
      handle_of[i] = '0;
      next_of[i] = 0;
      freed_stack[i] = 0;
    end
    freed_depth = 0;
    fresh_next = 0;
    live_count = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, each operation, missing keys, unused kind
    pending_ops.push_back(make_op(KindLookup, '0, '0));
    pending_ops.push_back(make_op(KindRemove, '1, '1));
    pending_ops.push_back(make_op(KindPut, '0, '1));
    pending_ops.push_back(make_op(KindPut, '1, '0));
    pending_ops.push_back(make_op(KindPut, 32'h0000_0100, 32'h5555_5555));
    pending_ops.push_back(make_op(KindPut, 32'h0000_0200, 32'hAAAA_AAAA));
    pending_ops.push_back(make_op(KindLookup, '0, '0));
    pending_ops.push_back(make_op(KindLookup, 32'h0000_0100, '0));
    pending_ops.push_back(make_op(KindPut, 32'h0000_0100, 32'h1234_5678));
    pending_ops.push_back(make_op(KindLookup, 32'h0000_0100, '1));
    pending_ops.push_back(make_op(KindNone, 32'h0000_0200, '1));
    pending_ops.push_back(make_op(KindRemove, 32'h0000_0100, '0));
    pending_ops.push_back(make_op(KindRemove, 32'h0000_0100, '0));
    pending_ops.push_back(make_op(KindLookup, 32'h0000_0200, '0));
    pending_ops.push_back(make_op(KindRemove, '0, '0));
    pending_ops.push_back(make_op(KindPut, 32'h0000_0300, 32'h0F0F_0F0F));
    pending_ops.push_back(make_op(KindLookup, '1, '0));
    wait_drained();

    // fill the pool past capacity while the receiver holds off
    long_hold_req = 1'b1;
    for (int i = 0; i < NumSlots + 8; i++) begin
      k = (i % 64) * NumBuckets + (i / 64) * 7 + 32'h1000_0000;
      if (i % 3 == 0) k = $urandom();
      pending_ops.push_back(make_op(KindPut, k, $urandom()));
      used_keys.push_back(k);
    end
    pending_ops.push_back(make_op(KindPut, 32'h0000_0100, $urandom()));
    pending_ops.push_back(make_op(KindPut, '1, $urandom()));
    wait_drained();

    // random mix of all four kinds; a long receiver hold starts midway
    for (int i = 0; i < 1500; i++) begin
      int unsigned r;
      logic [1:0] kind;
      r = $urandom_range(0, 99);
      if (r < 2) kind = KindNone;
      else if (r < 40) kind = KindPut;
      else if (r < 65) kind = KindLookup;
      else kind = KindRemove;
      pending_ops.push_back(make_op(kind, pick_key(), $urandom()));
      if (i == 750) begin
        wait_drained();
        long_hold_req = 1'b1;
      end
    end
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("ran %0d operations, %0d results checked, %0d hits, %0d refused puts",
             ops_sent, results_seen, hits_seen, full_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
